FILE: hdl/dwms_pkg.sv
`timescale 1ns / 1ps

package dwms_pkg;

  localparam int WINDOW  = 16;
  localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DATA_W  = 32;
  localparam int TOTAL_W = DATA_W + PTR_W;
  localparam int TICK_W  = 8;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_TICK = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] left_diff;
    logic signed [DATA_W-1:0] right_diff;
    logic [TICK_W-1:0]        tick_count;
  } dwms_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] left_window_sum;
    logic signed [DATA_W-1:0] right_window_sum;
    logic [1:0]               status;
  } dwms_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } dwms_state_t;

  // one tick slot update, shared by both lanes
  typedef struct packed {
    logic             step;
    logic             last;
    logic [PTR_W-1:0] ptr;
  } dwms_step_t;

  // result load request towards the output register
  typedef struct packed {
    logic load;
    logic bad;
  } dwms_fin_t;

endpackage

FILE: hdl/dwms_seq.sv
`timescale 1ns / 1ps

module dwms_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [dwms_pkg::TICK_W-1:0] in_ticks,
  output logic                        in_stall,
  input  logic                        out_free,
  output dwms_pkg::dwms_step_t        step,
  output dwms_pkg::dwms_fin_t         fin
);
  import dwms_pkg::*;

  dwms_state_t       state_r, state_nxt;
  logic [TICK_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic              bad_r, bad_nxt;
  logic              bad_ticks;

  assign bad_ticks = (in_ticks == '0) || ({24'd0, in_ticks} > WINDOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ptr_r   <= '0;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= ptr_nxt;
      bad_r   <= bad_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    bad_nxt   = bad_r;
    in_stall  = 1'b1;
    step.step = 1'b0;
    step.last = (cnt_r == TICK_W'(1));
    step.ptr  = ptr_r;
    fin.load  = 1'b0;
    fin.bad   = bad_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          bad_nxt = bad_ticks;
          cnt_nxt = in_ticks;
          state_nxt = bad_ticks ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        step.step = 1'b1;
        cnt_nxt   = cnt_r - TICK_W'(1);
        ptr_nxt   = (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + PTR_W'(1);
        if (cnt_r == TICK_W'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          fin.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/dwms_lane.sv
`timescale 1ns / 1ps

module dwms_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dwms_pkg::dwms_step_t                step,
  input  logic signed [dwms_pkg::DATA_W-1:0]  delta,
  output logic signed [dwms_pkg::TOTAL_W-1:0] total
);
  import dwms_pkg::*;

  logic [DATA_W-1:0]         ring_r [WINDOW];
  logic signed [TOTAL_W-1:0] total_r, total_nxt;
  logic signed [DATA_W-1:0]  entry_new;
  logic signed [DATA_W-1:0]  entry_old;

  assign entry_new = step.last ? delta : '0;
  assign entry_old = $signed(ring_r[step.ptr]);
  assign total_nxt = total_r - TOTAL_W'(entry_old) + TOTAL_W'(entry_new);
  assign total     = total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        ring_r[i] <= '0;
      end
    end else if (step.step) begin
      total_r           <= total_nxt;
      ring_r[step.ptr]  <= entry_new;
    end
  end

endmodule

FILE: hdl/dual_wheel_moving_window_sum_top.sv
`timescale 1ns / 1ps

// Dual wheel moving window sum.
// Input transfer (in_valid/in_stall) carries both wheel deltas and the
// elapsed tick count; each accepted transfer yields exactly one result
// transfer (out_valid/out_stall) with both window sums and a status.
// For a valid count (1..16) the sequencer runs one ring update per tick
// and then loads the result; for a bad count it loads it with no update.
// One tick slot is written per cycle in both rings by a single subtract/add
// per wheel; in_stall stays high while the sequencer updates the rings and
// waits to load, so a new input is taken only once the last one is done.
// The result sits in an output register: a new input is taken while it
// waits, but the next result is held back until out_stall drops, and
// in_stall stays high until it is loaded.
// Synchronous active-low reset clears both rings, totals and the slot
// pointer at once; the block is ready in the first cycle after reset.
module dual_wheel_moving_window_sum_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dwms_pkg::dwms_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dwms_pkg::dwms_out_t out_data
);
  import dwms_pkg::*;

  dwms_in_t                  item_r;
  dwms_out_t                 out_r, out_nxt;
  logic                      out_valid_r;
  logic                      out_free;
  logic                      in_xfer;
  dwms_step_t                step_c;
  dwms_fin_t                 fin_c;
  logic signed [TOTAL_W-1:0] left_total;
  logic signed [TOTAL_W-1:0] right_total;
  logic                      left_fits;
  logic                      right_fits;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  dwms_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ticks (in_data.tick_count),
    .in_stall (in_stall),
    .out_free (out_free),
    .step     (step_c),
    .fin      (fin_c)
  );

  dwms_lane u_left (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step_c),
    .delta (item_r.left_diff),
    .total (left_total)
  );

  dwms_lane u_right (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step_c),
    .delta (item_r.right_diff),
    .total (right_total)
  );

  assign left_fits  = (&left_total[TOTAL_W-1:DATA_W-1]) ||
                      !(|left_total[TOTAL_W-1:DATA_W-1]);
  assign right_fits = (&right_total[TOTAL_W-1:DATA_W-1]) ||
                      !(|right_total[TOTAL_W-1:DATA_W-1]);

  always_comb begin
    out_nxt.left_window_sum  = '0;
    out_nxt.right_window_sum = '0;
    if (fin_c.bad) begin
      out_nxt.status = STATUS_BAD_TICK;
    end else if (!left_fits || !right_fits) begin
      out_nxt.status = STATUS_OVERFLOW;
    end else begin
      out_nxt.status           = STATUS_OK;
      out_nxt.left_window_sum  = left_total[DATA_W-1:0];
      out_nxt.right_window_sum = right_total[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
    if (fin_c.load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_c.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step_c.step |-> in_stall)
    else $error("input transfer possible during tick update");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    fin_c.load |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a pending transfer");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STATUS_OK ||
                   out_data.status == STATUS_BAD_TICK ||
                   out_data.status == STATUS_OVERFLOW))
    else $error("undefined status code");

  a_bad_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.tick_count == '0)) |=> !step_c.step)
    else $error("tick update after zero tick count");
`endif

endmodule
